FILE: sv/vod_pkg.sv
package vod_pkg;

  localparam int COORD_W     = 32;
  localparam int CELL_W      = 31;
  localparam int INV_W       = 32;
  localparam int COUNT_OUT_W = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int AXES        = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X    = 3'd0,
    REG_MIN_Y    = 3'd1,
    REG_MIN_Z    = 3'd2,
    REG_CELL     = 3'd3,
    REG_INV_CELL = 3'd4
  } reg_idx_t;

  localparam logic [CELL_W-1:0] CELL_RESET = 31'd65536;
  localparam logic [INV_W-1:0]  INV_RESET  = 32'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic [CELL_W-1:0]         cell_size;
    logic [INV_W-1:0]          inv_cell_size;
  } vod_cfg_t;

endpackage

FILE: sv/vod_in_if.sv
interface vod_in_if;
  import vod_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic                      last_point;

  modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

FILE: sv/vod_out_if.sv
interface vod_out_if;
  import vod_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_W-1:0]     center_x;
  logic signed [COORD_W-1:0]     center_y;
  logic signed [COORD_W-1:0]     center_z;
  logic                          is_new;
  logic [COUNT_OUT_W-1:0]        unique_count;
  logic                          table_full;
  logic                          end_of_cloud;

  modport source (output valid, center_x, center_y, center_z, is_new, unique_count,
                  table_full, end_of_cloud, input ready);
  modport sink   (input valid, center_x, center_y, center_z, is_new, unique_count,
                  table_full, end_of_cloud, output ready);
endinterface

FILE: sv/vod_ram.sv
module vod_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/vod_voxel.sv
// Index and center per axis: one shared pipeline, the three axes enter on
// consecutive cycles. done pulses when the last axis leaves.
module vod_voxel #(
  parameter int INDEX_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [vod_pkg::COORD_W-1:0] coord [vod_pkg::AXES],
  input  vod_pkg::vod_cfg_t                  cfg,
  output logic                               done,
  output logic [3*INDEX_BITS-1:0]            key,
  output logic signed [vod_pkg::COORD_W-1:0] center [vod_pkg::AXES]
);
  import vod_pkg::*;

  localparam int PW = COORD_W + INV_W;
  localparam int CW = INDEX_BITS + CELL_W;
  localparam int SW = INDEX_BITS + COORD_W + 2;
  localparam logic [COORD_W-1:0] TOP = COORD_W'((1 << INDEX_BITS) - 1);

  logic [1:0] f_axis_r;
  logic       f_act_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic [1:0] a1_r, a2_r, a3_r, a4_r;
  logic signed [COORD_W:0] diff_r;
  logic       neg2_r;
  logic [PW-1:0] prod_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [CW-1:0] cprod_r;
  logic [INDEX_BITS-1:0] idx_st_r [AXES];

  logic signed [COORD_W-1:0] sel_coord, sel_min4;
  logic signed [COORD_W-1:0] min_by_axis [AXES];
  logic [COORD_W-1:0] q;
  logic [INDEX_BITS-1:0] idx_nxt;
  logic signed [SW-1:0] sum;

  assign min_by_axis[0] = cfg.min_x;
  assign min_by_axis[1] = cfg.min_y;
  assign min_by_axis[2] = cfg.min_z;
  assign sel_coord = coord[f_axis_r];
  assign sel_min4  = min_by_axis[a4_r];

  // floor of the product, clamped to the index range
  assign q = prod_r[PW-1:INV_W];
  always_comb begin
    if (neg2_r) begin
      idx_nxt = '0;
    end else if (q > TOP) begin
      idx_nxt = TOP[INDEX_BITS-1:0];
    end else begin
      idx_nxt = q[INDEX_BITS-1:0];
    end
  end

  // min + half cell + index * cell
  assign sum = SW'(sel_min4) + SW'({1'b0, cfg.cell_size[CELL_W-1:1]})
             + $signed({2'b00, cprod_r});

  // control: axis feed and valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_act_r  <= 1'b0;
      f_axis_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        f_act_r  <= 1'b1;
        f_axis_r <= '0;
      end else if (f_act_r) begin
        f_act_r  <= (f_axis_r != 2'd2);
        f_axis_r <= f_axis_r + 2'd1;
      end
      v1_r <= f_act_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      done <= v4_r && (a4_r == 2'd2);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    diff_r <= {sel_coord[COORD_W-1], sel_coord}
            - {min_by_axis[f_axis_r][COORD_W-1], min_by_axis[f_axis_r]};
    a1_r   <= f_axis_r;
    prod_r <= PW'(diff_r[COORD_W-1:0]) * PW'(cfg.inv_cell_size);
    neg2_r <= diff_r[COORD_W];
    a2_r   <= a1_r;
    idx_r  <= idx_nxt;
    a3_r   <= a2_r;
    if (v2_r) begin
      idx_st_r[a2_r] <= idx_nxt;
    end
    cprod_r <= CW'(idx_r) * CW'(cfg.cell_size);
    a4_r    <= a3_r;
    if (v4_r) begin
      if (sum[SW-1] && (sum[SW-1:COORD_W-1] != '1)) begin
        center[a4_r] <= {1'b1, {(COORD_W-1){1'b0}}};
      end else if (!sum[SW-1] && (sum[SW-1:COORD_W-1] != '0)) begin
        center[a4_r] <= {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        center[a4_r] <= sum[COORD_W-1:0];
      end
    end
  end

  assign key = {idx_st_r[0], idx_st_r[1], idx_st_r[2]};
endmodule

FILE: sv/voxel_occupancy_dedup.sv
// An accepted point goes through the voxel pipeline, then a scan of the stored keys
// (the distinct voxels stored so far in the cloud) until a hit or the last one;
// the key table scan reads one stored key per cycle from a two-port memory.
// Throughput: one point at a time; the next point is taken while a result waits.
// Reset (synchronous, rst_n low): registers to defaults, table empty at once;
// last_point empties the table by zeroing the fill count, no clearing pass.
module voxel_occupancy_dedup #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int INDEX_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  vod_in_if.sink                              in_ch,
  vod_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [vod_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vod_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import vod_pkg::*;

  localparam int KW = 3 * INDEX_BITS;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [NW-1:0] ENTRIES = NW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_SCAN, S_FINISH} state_t;

  state_t state_r;
  vod_cfg_t cfg_r;
  logic signed [COORD_W-1:0] coord_r [AXES];
  logic last_r;
  logic start_r;
  logic [NW-1:0] count_r, addr_r;
  logic pend_r, hit_r;
  logic [KW-1:0] key_r;

  logic v_done;
  logic [KW-1:0] v_key;
  logic signed [COORD_W-1:0] v_center [AXES];
  logic [KW-1:0] rdata;
  logic mem_we;
  logic issue;
  logic out_free;
  logic hit_now;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_x <= '0;
      cfg_r.min_y <= '0;
      cfg_r.min_z <= '0;
      cfg_r.cell_size <= CELL_RESET;
      cfg_r.inv_cell_size <= INV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X:    cfg_r.min_x <= cfg_wdata;
        REG_MIN_Y:    cfg_r.min_y <= cfg_wdata;
        REG_MIN_Z:    cfg_r.min_z <= cfg_wdata;
        REG_CELL:     cfg_r.cell_size <= cfg_wdata[CELL_W-1:0];
        REG_INV_CELL: cfg_r.inv_cell_size <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vod_voxel #(.INDEX_BITS(INDEX_BITS)) u_voxel (
    .clk(clk), .rst_n(rst_n), .start(start_r), .coord(coord_r), .cfg(cfg_r),
    .done(v_done), .key(v_key), .center(v_center)
  );

  vod_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_keys (
    .clk(clk), .we(mem_we), .waddr(count_r[AW-1:0]), .wdata(key_r),
    .raddr(addr_r[AW-1:0]), .rdata(rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign issue       = (state_r == S_SCAN) && (addr_r < count_r) && !hit_r;
  assign hit_now     = pend_r && (rdata == key_r);
  assign mem_we      = (state_r == S_FINISH) && out_free && !hit_r && (count_r < ENTRIES);

  // sequencer, scan and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
      count_r <= '0;
      addr_r  <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // a new result loaded in S_FINISH takes the place of the one leaving
      if (out_ch.valid && out_ch.ready && (state_r != S_FINISH)) begin
        out_ch.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            coord_r[0] <= in_ch.x_coord;
            coord_r[1] <= in_ch.y_coord;
            coord_r[2] <= in_ch.z_coord;
            last_r  <= in_ch.last_point;
            start_r <= 1'b1;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (v_done) begin
            key_r   <= v_key;
            addr_r  <= '0;
            pend_r  <= 1'b0;
            hit_r   <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_r <= issue;
          if (issue) begin
            addr_r <= addr_r + 1'b1;
          end
          if (hit_now) begin
            hit_r   <= 1'b1;
            state_r <= S_FINISH;
          end else if (!issue && !pend_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.center_x     <= v_center[0];
            out_ch.center_y     <= v_center[1];
            out_ch.center_z     <= v_center[2];
            out_ch.is_new       <= mem_we;
            out_ch.table_full   <= !hit_r && !mem_we;
            out_ch.end_of_cloud <= last_r;
            out_ch.unique_count <= COUNT_OUT_W'(mem_we ? count_r + 1'b1 : count_r);
            if (last_r) begin
              count_r <= '0;
            end else if (mem_we) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/tb.sv
module tb;
  import vod_pkg::*;

  localparam int  TBL_DEPTH   = 4096;
  localparam int  IDX_TOP     = 65535;
  localparam int  N_STEADY    = 8;
  localparam longint CYC_LIMIT = 64'd60_000_000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_t;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      is_new;
    logic [COUNT_OUT_W-1:0]    count;
    logic                      full;
    logic                      eoc;
  } voxel_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vod_in_if  in_ch();
  vod_out_if out_ch();

  voxel_occupancy_dedup uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the configuration and the occupancy set
  logic signed [COORD_W-1:0] box_min [AXES];
  logic [CELL_W-1:0]         cell_len;
  logic [INV_W-1:0]          cell_inv;
  bit                        occupied [bit [47:0]];
  int                        occ_count;

  point_t     pending_pts [$];
  voxel_res_t expected_vox [$];
  point_t     cur_pt;

  int     src_idle_pct;
  int     snk_stall_pct;
  bit     hold_req;
  int     hold_left;
  int     mismatches;
  longint cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // voxel index on one axis: floored product, clamped
  function automatic logic [15:0] axis_index(logic signed [31:0] c, logic signed [31:0] lo);
    longint     d;
    bit [63:0]  prod;
    d = longint'(c) - longint'(lo);
    if (d < 0) return 16'd0;
    prod = 64'(d) * 64'(cell_inv);
    prod = prod >> 32;
    return (prod > IDX_TOP) ? 16'hFFFF : prod[15:0];
  endfunction

  function automatic logic signed [31:0] axis_center(logic signed [31:0] lo, logic [15:0] idx);
    longint v;
    v = longint'(lo) + longint'(cell_len >> 1) + longint'(idx) * longint'(cell_len);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // expected result of one point, updating the occupancy set
  function automatic voxel_res_t dedup_point(point_t p);
    voxel_res_t r;
    logic [15:0] ix, iy, iz;
    bit [47:0]   key;
    ix = axis_index(p.x, box_min[0]);
    iy = axis_index(p.y, box_min[1]);
    iz = axis_index(p.z, box_min[2]);
    key = {ix, iy, iz};
    r.is_new = 1'b0;
    r.full   = 1'b0;
    if (!occupied.exists(key)) begin
      if (occ_count < TBL_DEPTH) begin
        occupied[key] = 1'b1;
        occ_count++;
        r.is_new = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    r.cx    = axis_center(box_min[0], ix);
    r.cy    = axis_center(box_min[1], iy);
    r.cz    = axis_center(box_min[2], iz);
    r.count = COUNT_OUT_W'(occ_count);
    r.eoc   = p.last;
    if (p.last) begin
      occupied.delete();
      occ_count = 0;
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.x_coord    <= '0;
      in_ch.y_coord    <= '0;
      in_ch.z_coord    <= '0;
      in_ch.last_point <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_vox.push_back(dedup_point(cur_pt));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pts.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_pt = pending_pts.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.x_coord    <= cur_pt.x;
          in_ch.y_coord    <= cur_pt.y;
          in_ch.z_coord    <= cur_pt.z;
          in_ch.last_point <= cur_pt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    voxel_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_vox.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
        end else begin
          e = expected_vox.pop_front();
          if (out_ch.center_x !== e.cx || out_ch.center_y !== e.cy ||
              out_ch.center_z !== e.cz || out_ch.is_new !== e.is_new ||
              out_ch.unique_count !== e.count || out_ch.table_full !== e.full ||
              out_ch.end_of_cloud !== e.eoc) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp c=(%0d %0d %0d) new=%0b cnt=%0d full=%0b eoc=%0b",
                        " | got c=(%0d %0d %0d) new=%0b cnt=%0d full=%0b eoc=%0b"},
                       e.cx, e.cy, e.cz, e.is_new, e.count, e.full, e.eoc,
                       out_ch.center_x, out_ch.center_y, out_ch.center_z, out_ch.is_new,
                       out_ch.unique_count, out_ch.table_full, out_ch.end_of_cloud);
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MIN_X:    box_min[0] = val;
      REG_MIN_Y:    box_min[1] = val;
      REG_MIN_Z:    box_min[2] = val;
      REG_CELL:     cell_len   = val[CELL_W-1:0];
      REG_INV_CELL: cell_inv   = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                          logic [31:0] cs, logic [31:0] inv);
    write_reg(REG_MIN_X, mx);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_MIN_Z, mz);
    write_reg(REG_CELL, cs);
    write_reg(REG_INV_CELL, inv);
  endtask

  task automatic wait_idle();
    while (pending_pts.size() > 0 || in_ch.valid || expected_vox.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic point_t mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic last);
    point_t p;
    p.x = x; p.y = y; p.z = z; p.last = last;
    return p;
  endfunction

  // coordinate near the box on one axis, saturated to 32 bits
  function automatic logic [31:0] near_coord(int ax);
    longint span, v;
    span = longint'(cell_len) * 48;
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    v = longint'(box_min[ax]) - span / 8 + longint'({$urandom} % (span + 1));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // one cloud: mostly revisits of a few voxels, some noise, last beat flagged (and now and then an earlier one)
  task automatic queue_cloud(int len);
    point_t pool [$];
    point_t p;
    for (int i = 0; i < 6; i++)
      pool.push_back(mk_point(near_coord(0), near_coord(1), near_coord(2), 1'b0));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       p = mk_point($urandom, $urandom, $urandom, 1'b0);
        1, 2, 3: p = mk_point(near_coord(0), near_coord(1), near_coord(2), 1'b0);
        default: p = pool[$urandom_range(pool.size() - 1)];
      endcase
      p.last = (i == len - 1) || ($urandom_range(99) == 0);
      pending_pts.push_back(p);
    end
  endtask

  initial begin
    logic [31:0] cs;
    mismatches = 0;
    cycles     = 0;
    hold_req   = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    box_min[0] = '0; box_min[1] = '0; box_min[2] = '0;
    cell_len  = CELL_RESET;
    cell_inv  = INV_RESET;
    occ_count = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default grid, extremes of coordinates, repeats, negatives
    pending_pts.push_back(mk_point(32'd0, 32'd0, 32'd0, 1'b0));
    pending_pts.push_back(mk_point(32'd0, 32'd0, 32'd0, 1'b0));
    pending_pts.push_back(mk_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
    pending_pts.push_back(mk_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    pending_pts.push_back(mk_point(32'hFFFFFFFF, 32'h0001FFFF, 32'h00010000, 1'b0));
    pending_pts.push_back(mk_point(32'h0000FFFF, 32'h00000001, 32'h7FFF0000, 1'b1));
    pending_pts.push_back(mk_point(32'd0, 32'd0, 32'd0, 1'b1));
    wait_idle();

    // finest grid from the most negative corner: large indexes clamp high
    set_grid(32'h80000000, 32'h80000000, 32'h80000000, 32'd1, 32'hFFFFFFFF);
    pending_pts.push_back(mk_point(32'h7FFFFFFF, 32'h80000000, 32'h80000010, 1'b0));
    pending_pts.push_back(mk_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b0));
    pending_pts.push_back(mk_point(32'h7FFFFFFF, 32'h80000000, 32'h80000010, 1'b1));
    wait_idle();

    // coarsest grid from the most positive corner: every point at or below the box corner
    set_grid(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd1);
    pending_pts.push_back(mk_point(32'h80000000, 32'h00000000, 32'h7FFFFFFF, 1'b0));
    pending_pts.push_back(mk_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
    wait_idle();

    // largest cell from the lowest corner: most centers saturate high
    set_grid(32'h80000000, 32'h00000000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    pending_pts.push_back(mk_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 1'b0));
    pending_pts.push_back(mk_point(32'h00000000, 32'h80000000, 32'h7FFFFFFF, 1'b1));
    wait_idle();

    // random phases across idling modes and grids
    for (int ph = 0; ph < N_STEADY; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 79; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 79; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      cs = $urandom_range(1, 32'h0004_0000);
      if (ph == 0) cs = 32'h0001_0000;
      set_grid($urandom, $urandom, $urandom, cs, 32'(64'h1_0000_0000_0000 / cs));
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 120; ) begin
        int len;
        len = $urandom_range(1, 40);
        queue_cloud(len);
        n += len;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: voxel_occupancy_dedup.f
sv/vod_pkg.sv
sv/vod_in_if.sv
sv/vod_out_if.sv
sv/vod_ram.sv
sv/vod_voxel.sv
sv/voxel_occupancy_dedup.sv
tb/sv/tb.sv
